// ===== src/overlap_add_block_fir_top_assert.svh =====
// ----------------------------------------------------------------------------
// overlap-add block fir assertion macros
// concurrent checks for the block's top module, empty when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef OVERLAP_ADD_BLOCK_FIR_TOP_ASSERT_SVH
`define OVERLAP_ADD_BLOCK_FIR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define OFIR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
// next-cycle implication
`define OFIR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define OFIR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define OFIR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/ofir_pkg.sv =====
// ----------------------------------------------------------------------------
// ofir_pkg
// shared widths, codes and control structs of the overlap-add block fir
// ----------------------------------------------------------------------------
package ofir_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TAPIDX_W   = 6;
   localparam int SHIFT_W    = 5;
   localparam int DIGIT_W    = 4;
   localparam int DIGITS     = SAMPLE_W / DIGIT_W;
   localparam int DCNT_W     = $clog2(DIGITS);
   localparam int PROD_W     = SAMPLE_W + DIGIT_W + 1;
   localparam int REQ_DATA_W = 40;

   localparam int FRAME_LEN_DEF = 64;
   localparam int TAP_COUNT_DEF = 64;
   localparam int ACC_WIDTH_DEF = 40;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd15;

   localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7fff;
   localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_TAP    = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic clear;
      logic load;
   } mac_ctl_type;

   typedef struct packed {
      logic busy;
      logic last;
   } mac_sts_type;

   typedef struct packed {
      logic load;
   } scl_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } scl_sts_type;

endpackage

// ===== src/ofir_mac.sv =====
// ----------------------------------------------------------------------------
// ofir_mac
// digit-serial multiply-accumulate, one 4-bit coefficient digit per cycle
// ----------------------------------------------------------------------------
module ofir_mac #(
   parameter int ACC_WIDTH = ofir_pkg::ACC_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ofir_pkg::mac_ctl_type               ctl,
   input  logic signed [ofir_pkg::SAMPLE_W-1:0] x,
   input  logic        [ofir_pkg::SAMPLE_W-1:0] h,
   output ofir_pkg::mac_sts_type               sts,
   output logic        [ACC_WIDTH-1:0]          acc
);

   logic signed [ofir_pkg::SAMPLE_W-1:0] x_ff;
   logic [ofir_pkg::SAMPLE_W-1:0]        h_sr_ff;
   logic [ofir_pkg::DCNT_W-1:0]          cnt_ff;
   logic                                 busy_ff;
   logic [ACC_WIDTH-1:0]                 acc_ff;
   logic [ACC_WIDTH-1:0]                 acc_in;
   logic                                 last;
   logic signed [ofir_pkg::DIGIT_W:0]    dig;
   logic signed [ofir_pkg::PROD_W-1:0]   prod;
   logic [ACC_WIDTH-1:0]                 term;

   assign last = busy_ff && (cnt_ff == ofir_pkg::DCNT_W'(ofir_pkg::DIGITS - 1));

   // top digit carries the sign of the coefficient
   always_comb begin
      if (last) begin
         dig = {h_sr_ff[ofir_pkg::DIGIT_W-1], h_sr_ff[ofir_pkg::DIGIT_W-1:0]};
      end else begin
         dig = {1'b0, h_sr_ff[ofir_pkg::DIGIT_W-1:0]};
      end
      prod   = ofir_pkg::PROD_W'(x_ff) * ofir_pkg::PROD_W'(dig);
      term   = ACC_WIDTH'(prod) << (ofir_pkg::DIGIT_W * int'(cnt_ff));
      acc_in = acc_ff + term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
      end
      if (ctl.load) begin
         x_ff    <= x;
         h_sr_ff <= h;
      end else if (busy_ff) begin
         h_sr_ff <= h_sr_ff >> ofir_pkg::DIGIT_W;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.last = last;
   assign acc      = acc_ff;

endmodule

// ===== src/ofir_scale.sv =====
// ----------------------------------------------------------------------------
// ofir_scale
// bit-serial magnitude shift toward zero, then saturation to 16 bits
// ----------------------------------------------------------------------------
module ofir_scale #(
   parameter int ACC_WIDTH = ofir_pkg::ACC_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ofir_pkg::scl_ctl_type               ctl,
   input  logic [ACC_WIDTH-1:0]                v,
   input  logic [ofir_pkg::SHIFT_W-1:0]        shift,
   output ofir_pkg::scl_sts_type               sts,
   output logic [ofir_pkg::SAMPLE_W-1:0]       res
);

   logic [ACC_WIDTH-1:0]            mag_ff;
   logic                            neg_ff;
   logic [ofir_pkg::SHIFT_W-1:0]    cnt_ff;
   logic                            busy_ff;
   logic                            done_ff;
   logic [ofir_pkg::SAMPLE_W-1:0]   res_ff;
   logic [ofir_pkg::SAMPLE_W-1:0]   sat;

   always_comb begin
      if (neg_ff) begin
         if (mag_ff > ACC_WIDTH'(32768)) begin
            sat = ofir_pkg::SAT_NEG;
         end else begin
            sat = -mag_ff[ofir_pkg::SAMPLE_W-1:0];
         end
      end else if (mag_ff > ACC_WIDTH'(32767)) begin
         sat = ofir_pkg::SAT_POS;
      end else begin
         sat = mag_ff[ofir_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !ctl.load && busy_ff && (cnt_ff == '0);
         if (ctl.load) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         neg_ff <= v[ACC_WIDTH-1];
         mag_ff <= v[ACC_WIDTH-1] ? (~v + 1'b1) : v;
         cnt_ff <= shift;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            res_ff <= sat;
         end else begin
            mag_ff <= mag_ff >> 1;
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign res      = res_ff;

endmodule

// ===== src/overlap_add_block_fir_top.sv =====
// ----------------------------------------------------------------------------
// overlap_add_block_fir_top
// block fir by overlap-add: frames of samples convolved with a tap store
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   req       in         req_tvalid/req_tready   tuser kind, tdata sample/tap
//   rsp       out        rsp_tvalid/rsp_tready   tdata filtered sample
//   csr       in         csr_valid/csr_ready     csr_data out_shift
//
// a coefficient item is written while idle; a sample item passes through the
// response state, which waits for a free output register, and leaves its
// result in the output register, which may wait for rsp_tready while the
// next item is taken; the item that completes a frame starts the convolution:
// each of the FRAME_LEN+TAP_COUNT-1 output terms passes through setup, wait
// and load, its tap products in the digit-serial multiply-accumulate, then
// post and store, and for frame outputs the serial scaler; no item is
// accepted until the last term is done
// reset is synchronous; the tap, tail and play-bank stores read as zero after
// reset by valid bits, no clearing pass
// ----------------------------------------------------------------------------
`include "overlap_add_block_fir_top_assert.svh"

module overlap_add_block_fir_top #(
   parameter int FRAME_LEN = ofir_pkg::FRAME_LEN_DEF,
   parameter int TAP_COUNT = ofir_pkg::TAP_COUNT_DEF,
   parameter int ACC_WIDTH = ofir_pkg::ACC_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [15:0] sample_in, [21:16] tap_index, [37:22] tap_value, [39:38] zero
   input  logic [ofir_pkg::REQ_DATA_W-1:0]       req_tdata,
   // [0] req_type
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [15:0] sample_out
   output logic [ofir_pkg::SAMPLE_W-1:0]         rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ofir_pkg::SHIFT_W-1:0]          csr_data
);

   localparam int POS_W     = $clog2(FRAME_LEN);
   localparam int BANK_AW   = POS_W + 1;
   localparam int TAP_W     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
   localparam int N_W       = $clog2(FRAME_LEN + TAP_COUNT);
   localparam int CONV_LAST = FRAME_LEN + TAP_COUNT - 2;

   typedef enum logic [3:0] {
      S_IDLE, S_RSP, S_SETUP, S_WAIT, S_LOAD, S_RUN, S_POST, S_STORE, S_SCALE
   } state_type;

   state_type                       state_ff;
   logic [POS_W-1:0]                pos_ff;
   logic                            bank_sel_ff;
   logic                            frame_done_ff;
   logic [ofir_pkg::SHIFT_W-1:0]    shift_ff;
   logic                            rsp_valid_ff;
   logic [ofir_pkg::SAMPLE_W-1:0]   rsp_data_ff;
   logic [N_W-1:0]                  n_ff;
   logic [POS_W-1:0]                i_ff;
   logic                            last_ff;
   logic [ACC_WIDTH-1:0]            v_ff;

   // request fields
   logic                            req_fire;
   logic                            req_sample;
   logic [ofir_pkg::SAMPLE_W-1:0]   sample_in;
   logic [ofir_pkg::TAPIDX_W-1:0]   tap_index;
   logic [ofir_pkg::SAMPLE_W-1:0]   tap_value;

   // stores
   logic [ofir_pkg::SAMPLE_W-1:0]   fill_mem [2**POS_W];
   logic [ofir_pkg::SAMPLE_W-1:0]   fill_rd_ff;
   logic [ofir_pkg::SAMPLE_W-1:0]   tap_mem [2**TAP_W];
   logic [ofir_pkg::SAMPLE_W-1:0]   tap_rd_ff;
   logic [2**TAP_W-1:0]             tap_vld_ff;
   logic                            tap_vld_rd_ff;
   logic [ACC_WIDTH-1:0]            tail_mem [2**TAP_W];
   logic [ACC_WIDTH-1:0]            tail_rd_ff;
   logic [2**TAP_W-1:0]             tail_vld_ff;
   logic [ofir_pkg::SAMPLE_W-1:0]   bank_mem [2**BANK_AW];
   logic [ofir_pkg::SAMPLE_W-1:0]   bank_rd_ff;
   logic [2**BANK_AW-1:0]           bank_vld_ff;
   logic                            bank_vld_rd_ff;

   // sequencing
   logic [N_W-1:0]                  lo_n;
   logic [POS_W-1:0]                lo;
   logic [POS_W-1:0]                hi;
   logic                            n_in_frame;
   logic                            n_last;
   logic [TAP_W-1:0]                tap_ra;
   logic [TAP_W-1:0]                tail_ra;
   logic [TAP_W-1:0]                tail_wa;
   logic [ACC_WIDTH-1:0]            tail_val;
   logic                            tap_we;
   logic                            tail_we;
   logic                            bank_we;
   logic                            rsp_free;

   ofir_pkg::mac_ctl_type           mac_ctl;
   ofir_pkg::mac_sts_type           mac_sts;
   logic [ACC_WIDTH-1:0]            mac_acc;
   ofir_pkg::scl_ctl_type           scl_ctl;
   ofir_pkg::scl_sts_type           scl_sts;
   logic [ofir_pkg::SAMPLE_W-1:0]   scl_res;

   assign req_fire   = req_tvalid && req_tready;
   assign req_sample = (req_tuser == ofir_pkg::REQ_SAMPLE);
   assign sample_in  = req_tdata[15:0];
   assign tap_index  = req_tdata[21:16];
   assign tap_value  = req_tdata[37:22];

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // product range of output term n: frame index lo..hi
   always_comb begin
      if (n_ff >= N_W'(TAP_COUNT - 1)) begin
         lo_n = n_ff - N_W'(TAP_COUNT - 1);
      end else begin
         lo_n = '0;
      end
      lo         = lo_n[POS_W-1:0];
      n_in_frame = (n_ff < N_W'(FRAME_LEN));
      hi         = n_in_frame ? n_ff[POS_W-1:0] : POS_W'(FRAME_LEN - 1);
      n_last     = (n_ff == N_W'(CONV_LAST));
   end

   assign tap_ra  = TAP_W'(n_ff - N_W'(i_ff));
   assign tail_ra = TAP_W'(n_ff);
   assign tail_wa = TAP_W'(n_ff - N_W'(FRAME_LEN));

   // saved tail only covers the first TAP_COUNT-1 terms
   assign tail_val = ((n_ff < N_W'(TAP_COUNT - 1)) && tail_vld_ff[tail_ra]) ?
                     tail_rd_ff : '0;

   assign tap_we  = req_fire && !req_sample &&
                    (32'(tap_index) < 32'(TAP_COUNT));
   assign tail_we = (state_ff == S_STORE) && !n_in_frame;
   assign bank_we = (state_ff == S_SCALE) && scl_sts.done;

   assign mac_ctl.clear = (state_ff == S_SETUP);
   assign mac_ctl.load  = (state_ff == S_LOAD) ||
                          ((state_ff == S_RUN) && mac_sts.last && !last_ff);
   assign scl_ctl.load  = (state_ff == S_STORE) && n_in_frame;

   ofir_mac #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .x     (fill_rd_ff),
      .h     (tap_vld_rd_ff ? tap_rd_ff : '0),
      .sts   (mac_sts),
      .acc   (mac_acc)
   );

   ofir_scale #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_scale (
      .clock (clock),
      .reset (reset),
      .ctl   (scl_ctl),
      .v     (v_ff),
      .shift (shift_ff),
      .sts   (scl_sts),
      .res   (scl_res)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pos_ff        <= '0;
         bank_sel_ff   <= 1'b0;
         frame_done_ff <= 1'b0;
         shift_ff      <= ofir_pkg::SHIFT_RESET;
         rsp_valid_ff  <= 1'b0;
         n_ff          <= '0;
         i_ff          <= '0;
         last_ff       <= 1'b0;
      end else begin
         if (csr_valid) begin
            shift_ff <= csr_data;
         end
         // the response state reloads the output register itself
         if (rsp_valid_ff && rsp_tready && (state_ff != S_RSP)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mac_ctl.load) begin
            last_ff <= (i_ff == hi);
            if (i_ff != hi) begin
               i_ff <= i_ff + 1'b1;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && req_sample) begin
                  frame_done_ff <= (pos_ff == POS_W'(FRAME_LEN - 1));
                  pos_ff <= (pos_ff == POS_W'(FRAME_LEN - 1)) ? '0 : pos_ff + 1'b1;
                  state_ff <= S_RSP;
               end
            end
            S_RSP: begin
               // played sample goes out; a full frame starts the convolution
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= bank_vld_rd_ff ? bank_rd_ff : '0;
                  n_ff         <= '0;
                  state_ff     <= frame_done_ff ? S_SETUP : S_IDLE;
               end
            end
            S_SETUP: begin
               i_ff     <= lo;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               state_ff <= S_RUN;
            end
            S_RUN: begin
               if (mac_sts.last && last_ff) begin
                  state_ff <= S_POST;
               end
            end
            S_POST: begin
               v_ff     <= mac_acc + tail_val;
               state_ff <= S_STORE;
            end
            S_STORE: begin
               if (n_in_frame) begin
                  state_ff <= S_SCALE;
               end else if (n_last) begin
                  bank_sel_ff <= !bank_sel_ff;
                  state_ff    <= S_IDLE;
               end else begin
                  n_ff     <= n_ff + 1'b1;
                  state_ff <= S_SETUP;
               end
            end
            S_SCALE: begin
               if (scl_sts.done) begin
                  if (n_last) begin
                     bank_sel_ff <= !bank_sel_ff;
                     state_ff    <= S_IDLE;
                  end else begin
                     n_ff     <= n_ff + 1'b1;
                     state_ff <= S_SETUP;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_vld_ff  <= '0;
         tail_vld_ff <= '0;
         bank_vld_ff <= '0;
      end else begin
         if (tap_we) begin
            tap_vld_ff[TAP_W'(tap_index)] <= 1'b1;
         end
         if (tail_we) begin
            tail_vld_ff[tail_wa] <= 1'b1;
         end
         if (bank_we) begin
            bank_vld_ff[{bank_sel_ff, n_ff[POS_W-1:0]}] <= 1'b1;
         end
      end
   end

   // current frame samples
   always_ff @(posedge clock) begin
      if (req_fire && req_sample) begin
         fill_mem[pos_ff] <= sample_in;
      end
      fill_rd_ff <= fill_mem[i_ff];
   end

   // coefficient store
   always_ff @(posedge clock) begin
      if (tap_we) begin
         tap_mem[TAP_W'(tap_index)] <= tap_value;
      end
      tap_rd_ff     <= tap_mem[tap_ra];
      tap_vld_rd_ff <= tap_vld_ff[tap_ra];
   end

   // overlap tail, read at term n and rewritten at term n+FRAME_LEN
   always_ff @(posedge clock) begin
      if (tail_we) begin
         tail_mem[tail_wa] <= v_ff;
      end
      tail_rd_ff <= tail_mem[tail_ra];
   end

   // two play banks; the read holds while the played sample waits
   always_ff @(posedge clock) begin
      if (bank_we) begin
         bank_mem[{bank_sel_ff, n_ff[POS_W-1:0]}] <= scl_res;
      end
      if (state_ff == S_IDLE) begin
         bank_rd_ff     <= bank_mem[{bank_sel_ff, pos_ff}];
         bank_vld_rd_ff <= bank_vld_ff[{bank_sel_ff, pos_ff}];
      end
   end

   `OFIR_ASSERT_NEXT(a_sample_blocks, clock, reset, req_fire && req_sample, !req_tready)
   `OFIR_ASSERT_IMP(a_mac_load, clock, reset, mac_ctl.load, !mac_sts.busy || mac_sts.last)
   `OFIR_ASSERT_IMP(a_scl_load, clock, reset, scl_ctl.load, !scl_sts.busy)
   `OFIR_ASSERT_IMP(a_idx_range, clock, reset, state_ff == S_RUN, i_ff <= hi)

endmodule
